// ===== rtl/core/acbm_pkg.sv =====
package acbm_pkg;

	localparam int NODE_COUNT = 64;
	localparam int ROW_W      = 6;
	localparam int ROW_BITS   = 64;
	localparam int ADDR_W     = ROW_W + 1;
	localparam int RAM_DEPTH  = 2 * (2 ** ROW_W);

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_NOTE  = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [ROW_W-1:0] first_node;
		logic [ROW_W-1:0] second_node;
		logic             axis;
	} req_t;

	typedef struct packed {
		logic aligned;
		logic infeasible;
	} rsp_t;

	function automatic logic [ROW_BITS-1:0] node_bit(input logic [ROW_W-1:0] idx);
		node_bit = ROW_BITS'(1) << idx;
	endfunction

endpackage

// ===== rtl/core/alignment_class_bit_matrix.sv =====
// Pairwise alignment relation over node indices, held as rows of 64 bits in two RAMs: one for
// the aligned tables and one for the infeasible tables, each addressed by axis and row. Every
// request beat gives exactly one response beat with the aligned and infeasible bits of the pair
// after the operation. An add does one read-modify-write of an aligned row per cycle through
// the single RAM write port. Rows are cleared at reset through per-row valid flags, so no
// clearing pass is needed and the block takes requests straight after reset. One request is
// worked on at a time; the next may be accepted while the previous response beat is still
// waiting.
module alignment_class_bit_matrix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  acbm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output acbm_pkg::rsp_t rsp
);

	import acbm_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_AU   = 8'b0000_0010,
		S_AV   = 8'b0000_0100,
		S_MW   = 8'b0000_1000,
		S_NU   = 8'b0001_0000,
		S_NVR  = 8'b0010_0000,
		S_NV   = 8'b0100_0000,
		S_RES  = 8'b1000_0000
	} state_t;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NODE_COUNT - 1);

	state_t                state_q, state_d;
	req_t                  op_q;
	logic                  oor_q;
	logic [ROW_BITS-1:0]   au_q, av_q;
	logic [ROW_W-1:0]      row_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [RAM_DEPTH-1:0]  al_vld_q, inf_vld_q;
	logic [ADDR_W-1:0]     al_raddr_q, inf_raddr_q;

	logic                  al_we, al_re, inf_we, inf_re;
	logic [ADDR_W-1:0]     al_waddr, al_raddr, inf_waddr, inf_raddr;
	logic [ROW_BITS-1:0]   al_wdata, inf_wdata, al_rdata, inf_rdata, al_row, inf_row;

	logic                  accept, oor_in, rsp_load;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign oor_in    = ({1'b0, req.first_node} >= (ROW_W + 1)'(NODE_COUNT)) ||
	                   ({1'b0, req.second_node} >= (ROW_W + 1)'(NODE_COUNT));
	assign rsp_load  = (state_q == S_RES) && (!rsp_valid_q || rsp_ready);

	assign al_row  = al_rdata & {ROW_BITS{al_vld_q[al_raddr_q]}};
	assign inf_row = inf_rdata & {ROW_BITS{inf_vld_q[inf_raddr_q]}};

	acbm_ram #(.WIDTH(ROW_BITS), .DEPTH(RAM_DEPTH)) u_al_ram (
		.clk   (clk),
		.we    (al_we),
		.waddr (al_waddr),
		.wdata (al_wdata),
		.re    (al_re),
		.raddr (al_raddr),
		.rdata (al_rdata)
	);

	acbm_ram #(.WIDTH(ROW_BITS), .DEPTH(RAM_DEPTH)) u_inf_ram (
		.clk   (clk),
		.we    (inf_we),
		.waddr (inf_waddr),
		.wdata (inf_wdata),
		.re    (inf_re),
		.raddr (inf_raddr),
		.rdata (inf_rdata)
	);

	always_comb begin
		state_d   = state_q;
		al_we     = 1'b0;
		al_waddr  = {op_q.axis, row_q};
		al_wdata  = al_row | (au_q[row_q] ? av_q : '0) | (av_q[row_q] ? au_q : '0);
		al_re     = 1'b0;
		al_raddr  = {op_q.axis, op_q.first_node};
		inf_we    = 1'b0;
		inf_waddr = {op_q.axis, op_q.first_node};
		inf_wdata = inf_row | node_bit(op_q.second_node);
		inf_re    = 1'b0;
		inf_raddr = {op_q.axis, op_q.first_node};
		case (state_q)
			S_IDLE: begin
				al_raddr  = {req.axis, req.first_node};
				inf_raddr = {req.axis, req.first_node};
				if (accept) begin
					if (oor_in) begin
						state_d = S_RES;
					end else begin
						case (req.func)
							FUNC_ADD: begin
								al_re   = 1'b1;
								state_d = S_AU;
							end
							FUNC_NOTE: begin
								inf_re  = 1'b1;
								state_d = S_NU;
							end
							default: begin
								al_re   = 1'b1;
								inf_re  = 1'b1;
								state_d = S_RES;
							end
						endcase
					end
				end
			end
			S_AU: begin
				al_re    = 1'b1;
				al_raddr = {op_q.axis, op_q.second_node};
				state_d  = S_AV;
			end
			S_AV: begin
				al_re    = 1'b1;
				al_raddr = {op_q.axis, ROW_W'(0)};
				state_d  = S_MW;
			end
			S_MW: begin
				al_we = 1'b1;
				if (row_q == LAST_ROW) begin
					// final read moves to the next cycle so it never meets the last write
					state_d = S_NV;
				end else begin
					al_re    = 1'b1;
					al_raddr = {op_q.axis, row_q + ROW_W'(1)};
				end
			end
			S_NU: begin
				inf_we  = 1'b1;
				state_d = S_NVR;
			end
			S_NVR: begin
				inf_re    = 1'b1;
				inf_raddr = {op_q.axis, op_q.second_node};
				state_d   = S_NV;
			end
			S_NV: begin
				if (op_q.func == FUNC_NOTE && !inf_re) begin
					inf_we    = 1'b1;
					inf_waddr = {op_q.axis, op_q.second_node};
					inf_wdata = inf_row | node_bit(op_q.first_node);
				end
				state_d = S_IDLE;
			end
			S_RES: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// both note and add finish through the final pair read
		if (state_q == S_NV) begin
			state_d = S_RES;
			al_re   = 1'b1;
			inf_re  = 1'b1;
			al_raddr  = {op_q.axis, op_q.first_node};
			if (op_q.func == FUNC_NOTE) begin
				inf_we    = 1'b1;
				inf_waddr = {op_q.axis, op_q.second_node};
				inf_wdata = inf_row | node_bit(op_q.first_node);
				// second row written now, so the pair read waits for the next cycle
				al_re   = 1'b0;
				inf_re  = 1'b0;
				state_d = S_AU;
			end
			inf_raddr = {op_q.axis, op_q.first_node};
		end
		if (state_q == S_AU && op_q.func == FUNC_NOTE) begin
			al_re     = 1'b1;
			al_raddr  = {op_q.axis, op_q.first_node};
			inf_re    = 1'b1;
			inf_raddr = {op_q.axis, op_q.first_node};
			state_d   = S_RES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			al_vld_q    <= '0;
			inf_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (al_we) begin
				al_vld_q[al_waddr] <= 1'b1;
			end
			if (inf_we) begin
				inf_vld_q[inf_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req;
			oor_q <= oor_in;
		end
		if (al_re) begin
			al_raddr_q <= al_raddr;
		end
		if (inf_re) begin
			inf_raddr_q <= inf_raddr;
		end
		if (state_q == S_AU && op_q.func == FUNC_ADD) begin
			au_q <= al_row | node_bit(op_q.first_node);
		end
		if (state_q == S_AV) begin
			av_q  <= al_row | node_bit(op_q.second_node);
			row_q <= '0;
		end
		if (state_q == S_MW) begin
			row_q <= row_q + ROW_W'(1);
		end
		if (rsp_load) begin
			rsp_q.aligned    <= !oor_q && al_row[op_q.second_node];
			rsp_q.infeasible <= !oor_q && inf_row[op_q.second_node];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_al_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(al_we && al_re && al_waddr == al_raddr))
		else $error("aligned row read and written in the same cycle");

	a_no_inf_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(inf_we && inf_re && inf_waddr == inf_raddr))
		else $error("infeasible row read and written in the same cycle");

	a_al_write_only_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		al_we |-> (state_q == S_MW) && (op_q.func == FUNC_ADD))
		else $error("aligned row written outside an add");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && oor_q |=> !rsp_q.aligned && !rsp_q.infeasible)
		else $error("out of range pair gave a set bit");

endmodule

// ===== rtl/core/acbm_ram.sv =====
module acbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
